FILE: rtl/core/bitmap_first_fit_allocator_core_macros.svh
// Assertion helpers shared by the allocator core.
// They expect clk and arst_n in scope.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bfa_pkg.sv
package bfa_pkg;

	localparam int OP_W      = 1;
	localparam int RUN_W     = 19;
	localparam int UNIT_W    = 18;
	localparam int STATUS_W  = 3;
	localparam int FREE_W    = 19;
	localparam int BLOCKS_W  = 7;
	localparam int ROVER_W   = 15;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOTAL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NORUN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;

	// register index, taken from paddr[2]
	localparam logic REG_USABLE_BLOCKS = 1'b0;

	typedef struct packed {
		logic take;
		logic check;
		logic scan_rd;
		logic scan_ev;
		logic mark_rd;
		logic mark_wr;
		logic retire;
		logic clear_step;
	} bfa_cmd_t;

	typedef struct packed {
		logic zero_size;
		logic is_free;
		logic over_total;
		logic over_free;
		logic retry;
		logic at_end;
		logic hit;
		logic mark_done;
		logic out_busy;
	} bfa_stat_t;

endpackage

FILE: rtl/core/bitmap_first_fit_allocator_core.sv
// Bitmap run allocator with a next-fit rover. The heap holds usable_blocks
// (capped at MAX_BLOCKS) blocks of BLOCK_UNITS units, one used bit per unit in
// a byte-wide memory. An allocate transfer scans bytes first-fit from the rover
// byte, skipping full bytes, and retries once from byte 0; a free transfer
// clears bits up to the map end and raises the free count, saturating at the
// total. Each item gives exactly one result transfer. A zero-size request or
// one rejected by the size checks goes from the check state straight to the
// finish state. A search reads, then evaluates, each bitmap byte scanned, with
// one more read step when it retries from byte 0. Marking reads, then writes,
// each byte and closes with one last read, because the single-port bitmap
// memory gives one registered read or one write per cycle.
// Writing usable_blocks starts a clearing pass that zeroes each map byte in
// turn, the map being the capped block count times BLOCK_UNITS/8 bytes;
// during it no item is taken. After reset the heap is empty, so no clearing
// pass runs until the register is written.
// The input is stalled from its transfer until the result reaches the output
// register, and for longer while a finished result waits behind an earlier one
// that has not been taken; the output register holds a result until it is taken.
module bitmap_first_fit_allocator_core #(
	parameter int MAX_BLOCKS  = 64,
	parameter int BLOCK_UNITS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]    paddr,
	input  logic [bfa_pkg::PDATA_W-1:0]    pwdata,
	output logic [bfa_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bfa_pkg::OP_W-1:0]       operation,
	input  logic [bfa_pkg::RUN_W-1:0]      run_length,
	input  logic [bfa_pkg::UNIT_W-1:0]     start_unit,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bfa_pkg::STATUS_W-1:0]   status,
	output logic [bfa_pkg::UNIT_W-1:0]     granted_unit,
	output logic [bfa_pkg::FREE_W-1:0]     free_units
);
	import bfa_pkg::*;

	logic                 cfg_wr;
	logic [BLOCKS_W-1:0]  usable_blocks_q;
	bfa_cmd_t             cmd;
	bfa_stat_t            st;

	// register index sits at paddr[2]; writes to other words are dropped
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_USABLE_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) usable_blocks_q <= '0;
		else if (cfg_wr) usable_blocks_q <= pwdata[BLOCKS_W-1:0];
	end

	assign prdata = (paddr[2] == REG_USABLE_BLOCKS) ? PDATA_W'(usable_blocks_q) : '0;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_wr   (cfg_wr),
		.st       (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	bfa_datapath #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.BLOCK_UNITS (BLOCK_UNITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.cfg_blocks   (pwdata[BLOCKS_W-1:0]),
		.operation    (operation),
		.run_length   (run_length),
		.start_unit   (start_unit),
		.cmd          (cmd),
		.st           (st),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.granted_unit (granted_unit),
		.free_units   (free_units)
	);

endmodule

FILE: rtl/core/bfa_ctrl.sv
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              cfg_wr,
	input  bfa_pkg::bfa_stat_t st,
	output bfa_pkg::bfa_cmd_t  cmd,
	output logic              in_stall
);
	import bfa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CHECK   = 8'b0000_0010,
		S_SCAN_RD = 8'b0000_0100,
		S_SCAN_EV = 8'b0000_1000,
		S_MARK_RD = 8'b0001_0000,
		S_MARK_WR = 8'b0010_0000,
		S_FINISH  = 8'b0100_0000,
		S_CLEAR   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (st.zero_size) state_d = S_FINISH;
				else if (st.is_free) state_d = S_MARK_RD;
				else if (st.over_total || st.over_free) state_d = S_FINISH;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (!st.at_end) state_d = S_SCAN_EV;
				else if (!st.retry) state_d = S_FINISH;
			end
			S_SCAN_EV: begin
				state_d = st.hit ? S_MARK_RD : S_SCAN_RD;
			end
			S_MARK_RD: begin
				state_d = st.mark_done ? S_FINISH : S_MARK_WR;
			end
			S_MARK_WR: begin
				state_d = S_MARK_RD;
			end
			S_FINISH: begin
				if (!st.out_busy) state_d = S_IDLE;
			end
			S_CLEAR: begin
				if (st.at_end) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_wr) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall       = (state_q != S_IDLE);
	assign cmd.take       = (state_q == S_IDLE) && in_valid;
	assign cmd.check      = (state_q == S_CHECK);
	assign cmd.scan_rd    = (state_q == S_SCAN_RD);
	assign cmd.scan_ev    = (state_q == S_SCAN_EV);
	assign cmd.mark_rd    = (state_q == S_MARK_RD);
	assign cmd.mark_wr    = (state_q == S_MARK_WR);
	assign cmd.retire     = (state_q == S_FINISH) && !st.out_busy;
	assign cmd.clear_step = (state_q == S_CLEAR);

endmodule

FILE: rtl/core/bfa_datapath.sv
module bfa_datapath #(
	parameter int MAX_BLOCKS  = 64,
	parameter int BLOCK_UNITS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [bfa_pkg::BLOCKS_W-1:0]      cfg_blocks,
	input  logic [bfa_pkg::OP_W-1:0]          operation,
	input  logic [bfa_pkg::RUN_W-1:0]         run_length,
	input  logic [bfa_pkg::UNIT_W-1:0]        start_unit,
	input  bfa_pkg::bfa_cmd_t                 cmd,
	output bfa_pkg::bfa_stat_t                st,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [bfa_pkg::STATUS_W-1:0]      status,
	output logic [bfa_pkg::UNIT_W-1:0]        granted_unit,
	output logic [bfa_pkg::FREE_W-1:0]        free_units
);
	import bfa_pkg::*;

	localparam int MAP_BYTES  = MAX_BLOCKS * BLOCK_UNITS / 8;
	localparam int ADDR_W     = $clog2(MAP_BYTES);
	localparam int CNT_W      = $clog2(MAP_BYTES + 1);
	localparam int TOT_W      = $clog2(MAX_BLOCKS * BLOCK_UNITS + 1);
	localparam int UW         = (TOT_W > RUN_W) ? TOT_W : RUN_W;
	localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
	localparam int EW         = (BLK_W > BLOCKS_W) ? BLK_W : BLOCKS_W;
	localparam int BYTE_UNITS = BLOCK_UNITS / 8;

	logic [7:0] mem [MAP_BYTES];
	logic [7:0] rd_data_q;

	logic [UW-1:0]       total_q, free_q, count_q;
	logic [CNT_W-1:0]    len_q, addr_q, rb_q;
	logic [2:0]          rbit_q, bit_q;
	logic [ROVER_W-1:0]  rover_q;
	logic                retry_q, set_q;
	logic [RUN_W-1:0]    rem_q, size_q;
	logic [OP_W-1:0]     op_q;
	logic [UNIT_W-1:0]   start_q;
	logic [STATUS_W-1:0] status_q;
	logic [UNIT_W-1:0]   granted_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [UNIT_W-1:0]   out_granted_q;
	logic [FREE_W-1:0]   out_free_q;

	logic [EW-1:0]       eff_blocks;
	logic [UW-1:0]       size_u;
	logic [UW:0]         free_sum;
	logic [UW-1:0]       free_sat;

	// byte evaluation
	logic [3:0]          tz;
	logic                seen;
	logic [2:0]          hi;
	logic                prefix_hit, inner_hit, hit;
	logic [2:0]          inner_pos;
	logic [7:0]          win;
	logic [CNT_W-1:0]    sb;
	logic [2:0]          sbit;

	// mark step
	logic [3:0]          span, nbits;
	logic [7:0]          low_mask, mask, mark_data;

	logic                rd_en, wr_en;
	logic [7:0]          wr_data;

	assign eff_blocks = (EW'(cfg_blocks) > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS)
		: EW'(cfg_blocks);
	assign size_u     = UW'(size_q);
	assign free_sum   = {1'b0, free_q} + (UW+1)'(size_q);
	assign free_sat   = (free_sum > {1'b0, total_q}) ? total_q : free_sum[UW-1:0];

	always_comb begin
		tz   = '0;
		seen = 1'b0;
		hi   = '0;
		for (int i = 0; i < 8; i++) begin
			if (rd_data_q[i]) begin
				seen = 1'b1;
				hi   = 3'(i);
			end else if (!seen) begin
				tz = tz + 4'd1;
			end
		end
	end

	// runs that open after a used bit inside the byte; lowest start wins
	always_comb begin
		win       = 8'((9'd1 << size_q[2:0]) - 9'd1);
		inner_hit = 1'b0;
		inner_pos = '0;
		for (int j = 7; j >= 1; j--) begin
			if ((size_q <= RUN_W'(7)) && rd_data_q[j-1]
					&& (((rd_data_q >> j) & win) == 8'd0)
					&& ((4'(j) + {1'b0, size_q[2:0]}) <= 4'd8)) begin
				inner_hit = 1'b1;
				inner_pos = 3'(j);
			end
		end
	end

	assign prefix_hit = ((UW+1)'(count_q) + (UW+1)'(tz)) >= (UW+1)'(size_u);
	assign hit        = prefix_hit || inner_hit;
	assign sb         = prefix_hit ? rb_q : addr_q;
	assign sbit       = prefix_hit ? rbit_q : inner_pos;

	assign span      = 4'd8 - {1'b0, bit_q};
	assign nbits     = (rem_q < RUN_W'(span)) ? rem_q[3:0] : span;
	assign low_mask  = (nbits == 4'd8) ? 8'hff : 8'((9'd1 << nbits) - 9'd1);
	assign mask      = low_mask << bit_q;
	assign mark_data = set_q ? (rd_data_q | mask) : (rd_data_q & ~mask);

	assign st.zero_size  = (size_q == '0);
	assign st.is_free    = (op_q == OP_FREE);
	assign st.over_total = (size_u > total_q);
	assign st.over_free  = (size_u > free_q);
	assign st.retry      = retry_q;
	assign st.at_end     = (addr_q >= len_q);
	assign st.hit        = hit;
	assign st.mark_done  = (addr_q >= len_q) || (rem_q == '0);
	assign st.out_busy   = out_valid_q && out_stall;

	assign rd_en   = cmd.scan_rd || cmd.mark_rd;
	assign wr_en   = (cmd.clear_step && !st.at_end) || cmd.mark_wr;
	assign wr_data = cmd.clear_step ? 8'h00 : mark_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr_q[ADDR_W-1:0]] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[addr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			len_q   <= '0;
			free_q  <= '0;
			rover_q <= '0;
			addr_q  <= '0;
			retry_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				total_q <= UW'(eff_blocks) * UW'(BLOCK_UNITS);
				len_q   <= CNT_W'(eff_blocks) * CNT_W'(BYTE_UNITS);
				addr_q  <= '0;
			end else if (cmd.clear_step) begin
				free_q <= total_q;
				if (!st.at_end) addr_q <= addr_q + 1'b1;
			end else if (cmd.check) begin
				if (st.is_free) begin
					addr_q <= CNT_W'(start_q[UNIT_W-1:3]);
					if (!st.zero_size) free_q <= free_sat;
				end else begin
					addr_q  <= CNT_W'(rover_q);
					retry_q <= (rover_q != '0);
				end
			end else if (cmd.scan_rd) begin
				if (st.at_end && retry_q) begin
					rover_q <= '0;
					retry_q <= 1'b0;
					addr_q  <= '0;
				end
			end else if (cmd.scan_ev) begin
				if (hit) begin
					addr_q  <= sb;
					free_q  <= free_q - size_u;
					rover_q <= ROVER_W'(sb);
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end else if (cmd.mark_wr) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// item payload and search scratch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= operation;
			size_q  <= run_length;
			start_q <= start_unit;
		end
		if (cmd.check) begin
			status_q  <= ST_OK;
			granted_q <= '0;
			bit_q     <= start_q[2:0];
			rem_q     <= size_q;
			set_q     <= 1'b0;
			count_q   <= '0;
			rb_q      <= CNT_W'(rover_q);
			rbit_q    <= '0;
			if (st.zero_size) status_q <= ST_ZERO;
			else if (!st.is_free && st.over_total) status_q <= ST_TOTAL;
			else if (!st.is_free && st.over_free) status_q <= ST_FREE;
		end
		if (cmd.scan_rd && st.at_end) begin
			count_q <= '0;
			rb_q    <= '0;
			rbit_q  <= '0;
			if (!retry_q) status_q <= ST_NORUN;
		end
		if (cmd.scan_ev) begin
			if (hit) begin
				bit_q     <= sbit;
				rem_q     <= size_q;
				set_q     <= 1'b1;
				granted_q <= UNIT_W'({sb, sbit});
			end else if (rd_data_q == 8'h00) begin
				count_q <= count_q + UW'(8);
			end else begin
				count_q <= UW'(3'd7 - hi);
				if (hi == 3'd7) begin
					rb_q   <= addr_q + 1'b1;
					rbit_q <= '0;
				end else begin
					rb_q   <= addr_q;
					rbit_q <= hi + 3'd1;
				end
			end
		end
		if (cmd.mark_wr) begin
			rem_q <= rem_q - RUN_W'(nbits);
			bit_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.retire) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.retire) begin
			out_status_q  <= status_q;
			out_granted_q <= granted_q;
			out_free_q    <= FREE_W'(free_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign granted_unit = out_granted_q;
	assign free_units   = out_free_q;

`include "bitmap_first_fit_allocator_core_macros.svh"

	`BFA_ASSERT_IMP(a_free_le_total, !cmd.clear_step, free_q <= total_q, "free count above total")
	`BFA_ASSERT_IMP(a_mark_in_map, cmd.mark_wr, addr_q < len_q, "bitmap write past map end")
	`BFA_ASSERT_IMP(a_count_below, cmd.scan_ev, count_q < size_u, "run count reached size unseen")
	`BFA_ASSERT_NXT(a_hit_in_map, cmd.scan_ev && hit && !cfg_wr, addr_q < len_q, "run start past map end")

endmodule

FILE: tb/tb_bitmap_first_fit_allocator_core.sv
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator_core;
	import bfa_pkg::*;

	localparam int MAX_BLOCKS  = 64;
	localparam int BLOCK_UNITS = 4096;
	localparam int MAP_BYTES   = MAX_BLOCKS * BLOCK_UNITS / 8;

	// One request as it crosses the input channel
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [RUN_W-1:0]  len;
		logic [UNIT_W-1:0] first;
	} request_t;

	// One answer as it crosses the result channel
	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [UNIT_W-1:0]   unit;
		logic [FREE_W-1:0]   fr;
	} answer_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	// Directed stimulus row: either a register write or a request, optionally with
	// the answer typed in by hand
	typedef struct {
		row_kind_t         kind;
		logic [6:0]        blocks;
		request_t          req;
		bit                typed;
		answer_t           ans;
	} plan_row_t;

	typedef struct {
		int first;
		int len;
	} run_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [PDATA_W-1:0]      pwdata;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         operation;
	logic [RUN_W-1:0]        run_length;
	logic [UNIT_W-1:0]       start_unit;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic [UNIT_W-1:0]       granted_unit;
	logic [FREE_W-1:0]       free_units;

	// Mirror of the heap state
	logic [7:0] heap_map [MAP_BYTES];
	int         heap_free;
	int         heap_rover;
	int         heap_blocks;

	answer_t    awaited_answers[$];
	run_t       live_runs[$];
	int         errors;
	bit         calm;
	bit         hold_req;

	bitmap_first_fit_allocator_core #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.BLOCK_UNITS (BLOCK_UNITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.run_length   (run_length),
		.start_unit   (start_unit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_unit (granted_unit),
		.free_units   (free_units)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run, clearing passes included
	initial begin
		#2_000_000_000;
		$display("bitmap_first_fit_allocator_core verification failed");
		$finish;
	end

	function automatic int heap_total();
		return (heap_blocks > MAX_BLOCKS ? MAX_BLOCKS : heap_blocks) * BLOCK_UNITS;
	endfunction

	// First-fit pass over the mirror from byte 'from'. A full byte is skipped
	// whole; a used bit 7 restarts the run at bit 0 of the next byte.
	function automatic bit find_run(int from, int size, output int first);
		int   len;
		int   cnt;
		int   rb;
		int   rbit;
		logic [7:0] v;
		len  = heap_total() / 8;
		cnt  = 0;
		rb   = from;
		rbit = 0;
		first = 0;
		for (int b = from; b < len; b++) begin
			v = heap_map[b];
			if (v == 8'hff) begin
				cnt  = 0;
				rb   = b + 1;
				rbit = 0;
				continue;
			end
			for (int i = 0; i < 8; i++) begin
				if (v[i]) begin
					cnt = 0;
					if (i < 7) begin
						rb   = b;
						rbit = i + 1;
					end else begin
						rb   = b + 1;
						rbit = 0;
					end
				end else begin
					cnt++;
				end
				if (cnt == size)
					break;
			end
			if (cnt == size) begin
				first = rb * 8 + rbit;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Set or clear a run of bits, never past the end of the managed map
	function automatic void paint_run(int first, int size, bit val);
		int lim;
		lim = heap_total();
		for (int u = first; u < first + size && u < lim; u++)
			heap_map[u / 8][u % 8] = val;
	endfunction

	function automatic void heap_configure(logic [6:0] blocks);
		heap_blocks = blocks;
		foreach (heap_map[i])
			heap_map[i] = 8'h00;
		heap_free = heap_total();
	endfunction

	// Advance the mirror by one request and return the answer it must give
	function automatic answer_t heap_apply(request_t r);
		answer_t a;
		int      size;
		int      first;
		int      total;
		bit      hit;
		run_t    rn;
		size   = r.len;
		total  = heap_total();
		a.st   = ST_OK;
		a.unit = '0;
		if (size == 0) begin
			a.st = ST_ZERO;
		end else if (r.op == OP_ALLOC) begin
			if (size > total) begin
				a.st = ST_TOTAL;
			end else if (size > heap_free) begin
				a.st = ST_FREE;
			end else begin
				hit = find_run(heap_rover, size, first);
				if (!hit && heap_rover != 0) begin
					heap_rover = 0;
					hit = find_run(0, size, first);
				end
				if (hit) begin
					paint_run(first, size, 1'b1);
					heap_free -= size;
					heap_rover = first / 8;
					a.unit = UNIT_W'(first);
					rn.first = first;
					rn.len = size;
					live_runs.push_back(rn);
				end else begin
					a.st = ST_NORUN;
				end
			end
		end else begin
			paint_run(r.first, size, 1'b0);
			heap_free += size;
			if (heap_free > total)
				heap_free = total;
		end
		a.fr = FREE_W'(heap_free);
		return a;
	endfunction

	function automatic plan_row_t cfg_row(logic [6:0] blocks);
		plan_row_t p;
		p = '{kind: ROW_CFG, blocks: blocks, req: '{OP_ALLOC, '0, '0}, typed: 1'b0,
			ans: '{ST_OK, '0, '0}};
		return p;
	endfunction

	function automatic plan_row_t req_row(logic [OP_W-1:0] op, int len, int first,
		bit typed = 1'b0, logic [STATUS_W-1:0] st = ST_OK, int unit = 0, int fr = 0);
		plan_row_t p;
		p = '{kind: ROW_REQ, blocks: '0, req: '{op, RUN_W'(len), UNIT_W'(first)},
			typed: typed, ans: '{st, UNIT_W'(unit), FREE_W'(fr)}};
		return p;
	endfunction

	// Drop the request, wait until every answer is in, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (awaited_answers.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// APB write in setup and access phases, then read it back
	task automatic write_blocks(logic [6:0] blocks);
		wait_drained();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_USABLE_BLOCKS, 2'b00};
		pwdata  <= PDATA_W'(blocks);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		heap_configure(blocks);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== blocks) begin
			$error("usable_blocks readback: expected %0d, actual %0d", blocks, prdata[6:0]);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one request, hold it until the transfer, then maybe leave a gap
	task automatic offer(request_t r, bit typed, answer_t hand);
		answer_t a;
		int      gap;
		@(negedge clk);
		in_valid   <= 1'b1;
		operation  <= r.op;
		run_length <= r.len;
		start_unit <= r.first;
		do @(posedge clk); while (in_stall);
		a = heap_apply(r);
		awaited_answers.push_back(typed ? hand : a);
		gap = 0;
		if (!calm) begin
			case ($urandom_range(99)) inside
				[0:64]:  gap = 0;
				[65:94]: gap = $urandom_range(3, 1);
				default: gap = $urandom_range(60, 10);
			endcase
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [OP_W-1:0] OP_ALLOC_OR_FREE(logic pick);
		return pick ? OP_FREE : OP_ALLOC;
	endfunction

	// Random request: mostly allocations and frees of runs handed out earlier,
	// the rest noise (stray frees, zero and oversized requests)
	function automatic request_t random_request();
		request_t r;
		int       total;
		int       pick;
		int       k;
		total   = heap_total();
		r.op    = OP_ALLOC;
		r.first = UNIT_W'($urandom());
		pick    = $urandom_range(99);
		if (pick < 55) begin
			case ($urandom_range(19)) inside
				[0:11]:  r.len = RUN_W'($urandom_range(32, 1));
				[12:16]: r.len = RUN_W'($urandom_range(512, 33));
				default: r.len = RUN_W'($urandom_range(total > 0 ? total : 1, 1));
			endcase
		end else if (pick < 85 && live_runs.size() > 0) begin
			k       = $urandom_range(live_runs.size() - 1);
			r.op    = OP_FREE;
			r.first = UNIT_W'(live_runs[k].first);
			r.len   = RUN_W'(live_runs[k].len);
			live_runs.delete(k);
		end else if (pick < 93) begin
			r.op  = OP_FREE;
			r.len = RUN_W'($urandom_range(600, 1));
			if ($urandom_range(3) != 0 && total > 0)
				r.first = UNIT_W'($urandom_range(total - 1));
		end else if (pick < 96) begin
			r.op  = OP_ALLOC_OR_FREE(r.first[0]);
			r.len = '0;
		end else begin
			r.op  = OP_ALLOC;
			r.len = RUN_W'($urandom());
		end
		return r;
	endfunction

	// Result side: random stalls, mostly short, a few long, plus a long hold-off
	initial begin
		int stall_left;
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = 400;
				hold_req   = 1'b0;
			end
			if (stall_left == 0 && !calm) begin
				case ($urandom_range(99)) inside
					[0:84]:  stall_left = 0;
					[85:96]: stall_left = $urandom_range(3, 1);
					default: stall_left = $urandom_range(80, 20);
				endcase
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each result transfer against the oldest awaited answer
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_answers.size() == 0) begin
				$error("result transfer with no answer awaited: status %0d", status);
				errors++;
			end else begin
				e = awaited_answers.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					errors++;
				end
				if (granted_unit !== e.unit) begin
					$error("granted_unit: expected %0d, actual %0d", e.unit, granted_unit);
					errors++;
				end
				if (free_units !== e.fr) begin
					$error("free_units: expected %0d, actual %0d", e.fr, free_units);
					errors++;
				end
			end
		end
	end

	initial begin
		plan_row_t  plan[$];
		logic [6:0] phase_blocks[$];
		int         phase_items[$];
		answer_t    none;
		request_t   r;

		errors     = 0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		operation  = OP_ALLOC;
		run_length = '0;
		start_unit = '0;
		none       = '{ST_OK, '0, '0};
		heap_rover = 0;
		heap_configure(7'd0);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty heap, full heap extremes, a rover left past the end
		// of a shrunken heap, a run blocked at bit 7, stray frees that overstate the
		// free count, and frees past the end of the map
		plan = '{
			req_row(OP_ALLOC, 1, 0, 1, ST_TOTAL, 0, 0),
			req_row(OP_FREE, 0, 0, 1, ST_ZERO, 0, 0),
			cfg_row(7'd64),
			req_row(OP_ALLOC, 262144, 0, 1, ST_OK, 0, 0),
			req_row(OP_ALLOC, 1, 0, 1, ST_FREE, 0, 0),
			req_row(OP_ALLOC, 0, 0, 1, ST_ZERO, 0, 0),
			req_row(OP_FREE, 262144, 0, 1, ST_OK, 0, 262144),
			req_row(OP_FREE, 1, 262143, 1, ST_OK, 0, 262144),
			req_row(OP_ALLOC, 524287, 0, 1, ST_TOTAL, 0, 262144),
			req_row(OP_ALLOC, 262000, 0, 1, ST_OK, 0, 144),
			req_row(OP_ALLOC, 8, 0, 1, ST_OK, 262000, 136),
			cfg_row(7'd1),
			req_row(OP_ALLOC, 1, 0, 1, ST_OK, 0, 4095),
			req_row(OP_ALLOC, 6, 0),
			req_row(OP_ALLOC, 1, 0),
			req_row(OP_FREE, 7, 0),
			req_row(OP_ALLOC, 8, 0),
			req_row(OP_ALLOC, 2048, 0),
			req_row(OP_FREE, 100, 4000),
			req_row(OP_ALLOC, 2100, 0),
			req_row(OP_FREE, 5, 262143),
			cfg_row(7'd0),
			req_row(OP_ALLOC, 5, 0, 1, ST_TOTAL, 0, 0)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_blocks(plan[i].blocks);
			else
				offer(plan[i].req, plan[i].typed, plan[i].ans);
		end
		live_runs.delete();

		// Random part: small heaps carry most items, the extremes only a few
		phase_blocks = '{7'd1, 7'd2, 7'd1, 7'd0, 7'd3, 7'd127, 7'd1, 7'd2};
		phase_items  = '{200, 150, 150, 20, 150, 30, 150, 100};
		foreach (phase_blocks[p]) begin
			write_blocks(phase_blocks[p]);
			live_runs.delete();
			calm = (p == 2);
			// hold the result side while requests keep coming, to back up the input
			if (p == 1)
				hold_req = 1'b1;
			for (int n = 0; n < phase_items[p]; n++) begin
				r = random_request();
				offer(r, 1'b0, none);
				// pause the request side until every answer is in
				if (p == 0 && n == phase_items[p] / 2) begin
					@(negedge clk);
					in_valid <= 1'b0;
					wait (awaited_answers.size() == 0);
				end
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		wait (awaited_answers.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && awaited_answers.size() == 0)
			$display("bitmap_first_fit_allocator_core verification clean");
		else
			$display("bitmap_first_fit_allocator_core verification failed");
		$finish;
	end

endmodule
